FILE: hw/rtl/mdbe_pkg.sv
// ----------------------------------------------------------------------------
// mdbe_pkg
// Shared types, constants and helpers of the marker-delimited block extractor.
// ----------------------------------------------------------------------------
package mdbe_pkg;

   localparam int MARKER_MAX_BYTES = 16;
   localparam int MARKER_SLOTS     = 16;
   localparam int MARKER_BITS      = MARKER_SLOTS * 8;
   localparam int LEN_W            = 5;
   localparam int IDX_W            = 4;
   localparam int COUNT_W          = 32;
   localparam int CSR_ADDR_W       = 6;
   localparam int CSR_DATA_W       = 64;

   localparam logic [LEN_W-1:0]   MARKER_MAX_LEN = LEN_W'(MARKER_MAX_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

   typedef enum logic [2:0] {
      PH_SEEK = 3'b001,
      PH_COPY = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      REG_START_LOW  = 3'd0,
      REG_START_HIGH = 3'd1,
      REG_START_LEN  = 3'd2,
      REG_END_LOW    = 3'd3,
      REG_END_HIGH   = 3'd4,
      REG_END_LEN    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [MARKER_BITS-1:0] start_marker;
      logic [LEN_W-1:0]       start_length;
      logic [MARKER_BITS-1:0] end_marker;
      logic [LEN_W-1:0]       end_length;
   } cfg_type;

   function automatic logic [7:0] marker_byte(input logic [MARKER_BITS-1:0] mk,
                                              input logic [IDX_W-1:0] idx);
      return mk[idx*8 +: 8];
   endfunction

   // lengths above the marker capacity clamp to it
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
      return (len > MARKER_MAX_LEN) ? MARKER_MAX_LEN : len;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
      return (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);
   endfunction

endpackage

FILE: hw/rtl/marker_delimited_block_extractor_top.sv
// ----------------------------------------------------------------------------
// marker_delimited_block_extractor_top
// Seeks a start marker in a byte stream, then copies bytes out until the end
// marker has been matched in order.
// Responses are registered, so a response appears in the cycle after its request
// transfer; a completed start marker sets burst_active_ff, and the first marker
// byte is then registered as a response. Throughput: one byte per cycle while
// the output is free and no replay runs; a completed start marker of N bytes
// sends N responses, with requests held off until the last of them is sent.
// Reset: synchronous; phase goes to done; match, count, burst and valid flags clear.
// ----------------------------------------------------------------------------
module marker_delimited_block_extractor_top import mdbe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_begin_block,
   input  logic                  req_stream_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_valid,
   output logic [COUNT_W-1:0]    rsp_copied_count,
   output logic                  rsp_block_complete,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   mdbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   match_ff, match_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               burst_active_ff, burst_active_in;
   logic [IDX_W-1:0]   burst_idx_ff, burst_idx_in;
   logic [LEN_W-1:0]   burst_len_ff, burst_len_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_out_byte_ff, rsp_out_byte_in;
   logic               rsp_byte_valid_ff, rsp_byte_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_complete_ff, rsp_complete_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               accept;
   phase_type          ph;
   logic [LEN_W-1:0]   mi;
   logic [COUNT_W-1:0] cnt;
   logic [COUNT_W-1:0] cnt_inc;
   logic [COUNT_W-1:0] burst_cnt;
   logic [LEN_W-1:0]   slen, elen;
   logic               smatch, ematch;
   logic [LEN_W-1:0]   mi_s, mi_e;
   logic               burst_end;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = out_free && !burst_active_ff;
   assign accept    = req_valid && req_ready;

   // begin_block takes effect before the rest of the item
   assign ph  = req_begin_block ? PH_SEEK : phase_ff;
   assign mi  = req_begin_block ? '0 : match_ff;
   assign cnt = req_begin_block ? '0 : count_ff;
   assign cnt_inc   = sat_inc(cnt);
   assign burst_cnt = sat_inc(count_ff);

   assign slen   = eff_len(cfg.start_length);
   assign elen   = eff_len(cfg.end_length);
   assign smatch = (mi < slen) && (req_data_byte == marker_byte(cfg.start_marker, mi[IDX_W-1:0]));
   assign ematch = (mi < elen) && (req_data_byte == marker_byte(cfg.end_marker, mi[IDX_W-1:0]));
   assign mi_s   = mi + LEN_W'(smatch);
   assign mi_e   = mi + LEN_W'(ematch);
   assign burst_end = ({1'b0, burst_idx_ff} + LEN_W'(1)) == burst_len_ff;

   always_comb begin
      phase_in          = phase_ff;
      match_in          = match_ff;
      count_in          = count_ff;
      burst_active_in   = burst_active_ff;
      burst_idx_in      = burst_idx_ff;
      burst_len_in      = burst_len_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_byte_valid_in = rsp_byte_valid_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_complete_in   = rsp_complete_ff;
      rsp_last_in       = rsp_last_ff;

      if (burst_active_ff && out_free) begin
         // replay the start marker bytes, one transfer per cycle while the output is free
         rsp_valid_in      = 1'b1;
         rsp_out_byte_in   = marker_byte(cfg.start_marker, burst_idx_ff);
         rsp_byte_valid_in = 1'b1;
         rsp_count_in      = burst_cnt;
         rsp_complete_in   = 1'b0;
         rsp_last_in       = 1'b0;
         count_in          = burst_cnt;
         burst_idx_in      = burst_idx_ff + IDX_W'(1);
         if (burst_end) begin
            burst_active_in = 1'b0;
         end
      end else if (accept) begin
         phase_in = ph;
         match_in = mi;
         count_in = cnt;
         if (req_stream_end) begin
            if (ph == PH_SEEK || ph == PH_COPY) begin
               rsp_valid_in      = 1'b1;
               rsp_out_byte_in   = '0;
               rsp_byte_valid_in = 1'b0;
               rsp_count_in      = cnt;
               rsp_complete_in   = 1'b0;
               rsp_last_in       = 1'b1;
               phase_in          = PH_DONE;
               match_in          = '0;
            end
         end else begin
            case (ph)
               PH_SEEK: begin
                  if (mi_s >= slen) begin
                     phase_in = PH_COPY;
                     match_in = '0;
                     if (slen != '0) begin
                        burst_active_in = 1'b1;
                        burst_idx_in    = '0;
                        burst_len_in    = slen;
                     end
                  end else begin
                     match_in = mi_s;
                  end
               end
               PH_COPY: begin
                  rsp_valid_in      = 1'b1;
                  rsp_out_byte_in   = req_data_byte;
                  rsp_byte_valid_in = 1'b1;
                  rsp_count_in      = cnt_inc;
                  count_in          = cnt_inc;
                  if (mi_e >= elen) begin
                     rsp_complete_in = 1'b1;
                     rsp_last_in     = 1'b1;
                     phase_in        = PH_DONE;
                     match_in        = '0;
                  end else begin
                     rsp_complete_in = 1'b0;
                     rsp_last_in     = 1'b0;
                     match_in        = mi_e;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_DONE;
         match_ff        <= '0;
         count_ff        <= '0;
         burst_active_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         match_ff        <= match_in;
         count_ff        <= count_in;
         burst_active_ff <= burst_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_idx_ff      <= burst_idx_in;
      burst_len_ff      <= burst_len_in;
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_byte_valid_ff <= rsp_byte_valid_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_complete_ff   <= rsp_complete_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_out_byte_ff;
   assign rsp_byte_valid     = rsp_byte_valid_ff;
   assign rsp_copied_count   = rsp_count_ff;
   assign rsp_block_complete = rsp_complete_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

FILE: hw/rtl/mdbe_csr.sv
// ----------------------------------------------------------------------------
// mdbe_csr
// APB-style register file holding the start and end markers and lengths.
// ----------------------------------------------------------------------------
module mdbe_csr import mdbe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_START_LOW:  cfg_in.start_marker[63:0]   = csr_pwdata;
            REG_START_HIGH: cfg_in.start_marker[127:64] = csr_pwdata;
            REG_START_LEN:  cfg_in.start_length         = csr_pwdata[LEN_W-1:0];
            REG_END_LOW:    cfg_in.end_marker[63:0]     = csr_pwdata;
            REG_END_HIGH:   cfg_in.end_marker[127:64]   = csr_pwdata;
            REG_END_LEN:    cfg_in.end_length           = csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_LOW:  csr_prdata = cfg_ff.start_marker[63:0];
         REG_START_HIGH: csr_prdata = cfg_ff.start_marker[127:64];
         REG_START_LEN:  csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cfg_ff.start_length};
         REG_END_LOW:    csr_prdata = cfg_ff.end_marker[63:0];
         REG_END_HIGH:   csr_prdata = cfg_ff.end_marker[127:64];
         REG_END_LEN:    csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cfg_ff.end_length};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
